[rtl/compacting_list_store_unit_defines.svh]
// assertion macros for the compacting list store unit
`ifndef COMPACTING_LIST_STORE_UNIT_DEFINES_SVH
`define COMPACTING_LIST_STORE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property sampled on i_clk, off while reset is held
`define CLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// antecedent now, consequent in the next cycle
`define CLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CLS_ASSERT(label, prop, msg)
`define CLS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/cls_pkg.sv]
// shared types and constants of the compacting list store unit
`timescale 1ns / 1ps
`default_nettype none

package cls_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // widths of the item fields
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int RDATA_W  = 32;
    localparam int COUNT_W  = 5;

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef logic [IDX_W-1:0]      t_ptr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [RDATA_W-1:0]    t_rdata;
    typedef logic [COUNT_W-1:0]    t_count;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND       = 2'd0,
        CMD_REMOVE_VALUE = 2'd1,
        CMD_REMOVE_INDEX = 2'd2,
        CMD_READ         = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    // one write and one read port request toward the word store
    typedef struct packed {
        logic  we;
        t_ptr  waddr;
        t_word wdata;
        t_ptr  raddr;
    } t_mem_req;

    typedef struct packed {
        t_status status;
        t_rdata  read_data;
        t_count  count;
    } t_result;

endpackage

`default_nettype wire

[rtl/cls_mem.sv]
// word store: one write port, one read port with registered data
`timescale 1ns / 1ps
`default_nettype none

module cls_mem (
    input  wire logic             i_clk,
    input  wire cls_pkg::t_mem_req i_req,
    output cls_pkg::t_word        o_rdata
);

    cls_pkg::t_word r_mem [cls_pkg::DEPTH];
    cls_pkg::t_word r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_q <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

[rtl/cls_ctrl.sv]
// command sequencer: search, compacting shift, read and append over the word store
`timescale 1ns / 1ps
`default_nettype none
`include "compacting_list_store_unit_defines.svh"

module cls_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire cls_pkg::t_cmd     i_cmd,
    input  wire logic [cls_pkg::VALUE_W-1:0] i_value,
    input  wire logic [cls_pkg::INDEX_W-1:0] i_index,
    output cls_pkg::t_mem_req      o_mem_req,
    input  wire cls_pkg::t_word    i_mem_q,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output cls_pkg::t_result       o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT,
        S_SH_WR,
        S_DONE
    } t_state;

    t_state           r_state,  n_state;
    cls_pkg::t_cnt    r_cnt,    n_cnt;
    cls_pkg::t_ptr    r_ptr,    n_ptr;
    cls_pkg::t_word   r_val,    n_val;
    cls_pkg::t_status r_status, n_status;
    cls_pkg::t_rdata  r_rdata,  n_rdata;

    logic          accept;
    logic          idx_bad;
    logic          list_full;
    logic          hit;
    cls_pkg::t_cnt ptr_next;
    logic          at_tail;

    assign accept    = i_valid && o_ready;
    assign idx_bad   = 32'(i_index) >= 32'(r_cnt);
    assign list_full = 32'(r_cnt) >= 32'(cls_pkg::DEPTH);
    // single comparator: the walked entry against the search word
    assign hit       = (i_mem_q == r_val);
    assign ptr_next  = cls_pkg::t_cnt'(r_ptr) + cls_pkg::t_cnt'(1);
    assign at_tail   = ptr_next >= r_cnt;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ptr     = r_ptr;
        n_val     = r_val;
        n_status  = r_status;
        n_rdata   = r_rdata;
        o_mem_req = '{we: 1'b0, waddr: r_ptr, wdata: i_mem_q, raddr: r_ptr};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val    = cls_pkg::t_word'(i_value);
                    n_rdata  = '0;
                    n_status = cls_pkg::ST_OK;
                    n_ptr    = '0;
                    o_mem_req.raddr = '0;
                    case (i_cmd)
                        cls_pkg::CMD_APPEND: begin
                            if (list_full) begin
                                n_status = cls_pkg::ST_FULL;
                            end else begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = cls_pkg::t_ptr'(r_cnt);
                                o_mem_req.wdata = cls_pkg::t_word'(i_value);
                                n_cnt = r_cnt + cls_pkg::t_cnt'(1);
                            end
                            n_state = S_DONE;
                        end
                        cls_pkg::CMD_REMOVE_VALUE: begin
                            if (r_cnt == '0) begin
                                n_status = cls_pkg::ST_NOT_FOUND;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SRCH_CMP;
                            end
                        end
                        cls_pkg::CMD_REMOVE_INDEX: begin
                            if (idx_bad) begin
                                n_status = cls_pkg::ST_BAD_INDEX;
                                n_state  = S_DONE;
                            end else begin
                                n_ptr   = cls_pkg::t_ptr'(i_index);
                                n_state = S_SHIFT;
                            end
                        end
                        cls_pkg::CMD_READ: begin
                            if (idx_bad) begin
                                n_status = cls_pkg::ST_BAD_INDEX;
                                n_state  = S_DONE;
                            end else begin
                                o_mem_req.raddr = cls_pkg::t_ptr'(i_index);
                                n_state = S_RD_WAIT;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_rdata = cls_pkg::t_rdata'(i_mem_q);
                n_state = S_DONE;
            end
            S_SRCH_RD: begin
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (hit) begin
                    n_state = S_SHIFT;
                end else if (at_tail) begin
                    n_status = cls_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_ptr   = cls_pkg::t_ptr'(ptr_next);
                    n_state = S_SRCH_RD;
                end
            end
            S_SHIFT: begin
                // pull the next entry down, or drop the tail
                if (at_tail) begin
                    n_cnt   = r_cnt - cls_pkg::t_cnt'(1);
                    n_state = S_DONE;
                end else begin
                    o_mem_req.raddr = cls_pkg::t_ptr'(ptr_next);
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_mem_req.we = 1'b1;
                n_ptr   = cls_pkg::t_ptr'(ptr_next);
                n_state = S_SHIFT;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_ptr    <= n_ptr;
        r_val    <= n_val;
        r_status <= n_status;
        r_rdata  <= n_rdata;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{status:    r_status,
                           read_data: r_rdata,
                           count:     cls_pkg::t_count'(r_cnt)};

    `CLS_ASSERT(a_cnt_bound, 32'(r_cnt) <= 32'(cls_pkg::DEPTH), "entry count beyond depth")
    `CLS_ASSERT_NEXT(a_busy_after_accept, accept, !o_ready, "ready right after accept")
    `CLS_ASSERT(a_full_status, !o_res_valid || r_status != cls_pkg::ST_FULL || list_full, "full status on a list with room")
    `CLS_ASSERT(a_write_in_list, !o_mem_req.we || 32'(o_mem_req.waddr) <= 32'(r_cnt), "write beyond list end")

endmodule

`default_nettype wire

[rtl/compacting_list_store_unit.sv]
// top level of the compacting list store unit: stream ports and result register
//
// channel | dir | tdata                                     | tuser
// s       | in  | [31:0] item_value, [35:32] index, 0 pad   | [1:0] cmd
// m       | out | [31:0] read_data, [36:32] count, 0 pad    | [1:0] status
//
// one command at a time; s_tready is high only while the sequencer is idle
// append or a refused command goes straight to the result; read waits for the
// registered store data; a removal walks the store entry by entry (search up
// to the hit, then shift the rest down); worst is a remove-value on a full list
// result register lets the next command start while a result waits on m_tready
// synchronous active-low reset clears the count and handshake state only
`timescale 1ns / 1ps
`default_nettype none

module compacting_list_store_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // item_value, index, zero pad
    input  wire logic [1:0]  i_s_tuser,   // cmd
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // read_data, count, zero pad
    output logic [1:0]       o_m_tuser    // status
);

    cls_pkg::t_mem_req mem_req;
    cls_pkg::t_word    mem_q;
    cls_pkg::t_result  res;
    logic              res_valid;
    logic              res_ready;

    // result register
    logic             r_out_valid;
    cls_pkg::t_result r_out;

    cls_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_q)
    );

    cls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_cmd       (cls_pkg::t_cmd'(i_s_tuser)),
        .i_value     (i_s_tdata[31:0]),
        .i_index     (i_s_tdata[35:32]),
        .o_mem_req   (mem_req),
        .i_mem_q     (mem_q),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // the slot takes a new result when empty or when drained this cycle
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.count, r_out.read_data};
    assign o_m_tuser  = r_out.status;

endmodule

`default_nettype wire
